// ----- sv/gra_pkg.sv -----
// ----------------------------------------------------------------------------
// gra_pkg
// Shared types, constants and lookup functions for the glyph ROM address
// pipeline.
// ----------------------------------------------------------------------------
package gra_pkg;

  localparam int unsigned SizeW   = 6;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned IndexW  = 13;  // largest glyph index is 7614
  localparam int unsigned CountW  = 8;
  localparam int unsigned ProdW   = IndexW + CountW;
  localparam int unsigned AddrW   = 24;

  localparam logic [SizeW-1:0] SizeReset = 6'd16;

  // GB2312 layout
  localparam logic [CodeW-1:0]  LowFirst    = 8'hA1;
  localparam logic [CodeW-1:0]  SymRowFirst = 8'hA1;
  localparam logic [CodeW-1:0]  SymRowLast  = 8'hA9;
  localparam logic [CodeW-1:0]  HanRowFirst = 8'hB0;
  localparam logic [CodeW-1:0]  HanRowLast  = 8'hF7;
  localparam logic [IndexW-1:0] RowLen      = 13'd94;
  localparam logic [IndexW-1:0] HanziOffset = 13'd846;

  // ASCII layout
  localparam logic [CodeW-1:0] AscFirst = 8'h20;
  localparam logic [CodeW-1:0] AscLast  = 8'h7E;
  localparam logic [CountW-1:0] AscCount24 = 8'd48;

  // Base addresses
  localparam logic [AddrW-1:0] HzBase16  = 24'h02C9D0;
  localparam logic [AddrW-1:0] HzBase24  = 24'h068190;
  localparam logic [AddrW-1:0] HzBase32  = 24'h0EDF00;
  localparam logic [AddrW-1:0] AscBase7  = 24'h1DDF80;
  localparam logic [AddrW-1:0] AscBase8  = 24'h1DE280;
  localparam logic [AddrW-1:0] AscBase12 = 24'h1DBE00;
  localparam logic [AddrW-1:0] AscBase16 = 24'h1DD780;
  localparam logic [AddrW-1:0] AscBase24 = 24'h1DFF00;
  localparam logic [AddrW-1:0] AscBase32 = 24'h1E5A50;

  // Lookup operation
  typedef enum logic {
    OP_GB2312 = 1'b0,
    OP_ASCII  = 1'b1
  } op_t;

  // Decode stage output
  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] index;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  base;
  } dec_t;

  // Multiply stage output
  typedef struct packed {
    logic              found;
    logic [ProdW-1:0]  product;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  base;
  } mul_t;

  function automatic logic [AddrW-1:0] hz_base(input logic [SizeW-1:0] s);
    logic [AddrW-1:0] b;
    case (s)
      6'd16:   b = HzBase16;
      6'd24:   b = HzBase24;
      6'd32:   b = HzBase32;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [AddrW-1:0] asc_base(input logic [SizeW-1:0] s);
    logic [AddrW-1:0] b;
    case (s)
      6'd7:    b = AscBase7;
      6'd8:    b = AscBase8;
      6'd12:   b = AscBase12;
      6'd16:   b = AscBase16;
      6'd24:   b = AscBase24;
      6'd32:   b = AscBase32;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/glyph_rom_address.sv -----
// ----------------------------------------------------------------------------
// glyph_rom_address
// Font ROM address generator for GB2312 and ASCII glyphs.
// ----------------------------------------------------------------------------
// Takes one character code per clock when the output is not stalled and
// returns one result per code, in order. The three register stages are
// decode (range check, glyph index, byte count, base address), a 13 x 8
// multiply of index by bytes per glyph, and the base add in the output
// register. Throughput is one transaction per clock without back-pressure;
// s_tready follows m_tready through the stage chain, and empty stages are
// filled while the output is held. glyph_size is written through the cfg
// channel, which is always ready; write it only while the pipe is empty.
module glyph_rom_address (
  input  logic        clk,
  input  logic        rst,
  // configuration: glyph_size
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] code_high, [15:8] code_low
  input  logic [0:0]  s_tuser,   // [0] operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [23:0] rom_address, [31:24] byte_count
  output logic [0:0]  m_tuser    // [0] found
);
  import gra_pkg::*;

  logic [SizeW-1:0]  glyph_size;
  logic              dec_valid;
  logic              dec_ready;
  dec_t              dec_data;
  logic              mul_valid;
  logic              mul_ready;
  mul_t              mul_data;
  logic              found;
  logic [AddrW-1:0]  rom_address;
  logic [CountW-1:0] byte_count;

  // size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_size <= SizeReset;
    end else if (cfg_valid && cfg_ready) begin
      glyph_size <= cfg_data;
    end
  end

  // pipeline stages
  gra_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .glyph_size (glyph_size),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .operation  (s_tuser[0]),
    .code_high  (s_tdata[7:0]),
    .code_low   (s_tdata[15:8]),
    .out_valid  (dec_valid),
    .out_ready  (dec_ready),
    .out_data   (dec_data)
  );

  gra_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  gra_addr u_addr (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mul_valid),
    .in_ready    (mul_ready),
    .in_data     (mul_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .found       (found),
    .rom_address (rom_address),
    .byte_count  (byte_count)
  );

  assign m_tdata = {byte_count, rom_address};
  assign m_tuser = found;

  // reset empties the pipe
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a full, stalled pipe takes nothing new
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && dec_valid && mul_valid |-> !s_tready)
    else $error("input accepted into a full stalled pipe");

  // an empty stage always has room
  assert property (@(posedge clk) disable iff (rst)
    !dec_valid |-> s_tready)
    else $error("input refused with an empty decode stage");

endmodule

// ----- sv/gra_decode.sv -----
// ----------------------------------------------------------------------------
// gra_decode
// First stage: range check of the code, glyph index, byte count and base.
// ----------------------------------------------------------------------------
module gra_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [gra_pkg::SizeW-1:0] glyph_size,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     operation,
  input  logic [gra_pkg::CodeW-1:0] code_high,
  input  logic [gra_pkg::CodeW-1:0] code_low,
  output logic                     out_valid,
  input  logic                     out_ready,
  output gra_pkg::dec_t            out_data
);
  import gra_pkg::*;

  logic              valid;
  dec_t              data;
  dec_t              data_next;

  logic [3:0]        rows;
  logic [9:0]        hz_prod;
  logic [9:0]        asc_prod;
  logic [CountW-1:0] hz_count;
  logic [CountW-1:0] asc_count;
  logic              low_ok;
  logic              sym_row;
  logic              han_row;
  logic              asc_ok;
  logic [IndexW-1:0] row;
  logic [IndexW-1:0] col;
  logic [IndexW-1:0] hz_index;

  // bytes per glyph from the size register
  assign rows      = 4'((7'(glyph_size) + 7'd7) >> 3);
  assign hz_prod   = 10'(rows) * 10'(glyph_size);
  assign asc_prod  = 10'(rows) * 10'(glyph_size >> 1);
  assign hz_count  = hz_prod[CountW-1:0];
  assign asc_count = (glyph_size == 6'd24) ? AscCount24 : asc_prod[CountW-1:0];

  // code range checks
  assign low_ok  = (code_low >= LowFirst);
  assign sym_row = low_ok && (code_high >= SymRowFirst) && (code_high <= SymRowLast);
  assign han_row = low_ok && (code_high >= HanRowFirst) && (code_high <= HanRowLast);
  assign asc_ok  = (code_high >= AscFirst) && (code_high <= AscLast);

  // GB2312 glyph index
  assign row      = han_row ? 13'(code_high - HanRowFirst) : 13'(code_high - SymRowFirst);
  assign col      = 13'(code_low - LowFirst);
  assign hz_index = row * RowLen + col + (han_row ? HanziOffset : '0);

  // next stage contents; misses carry zeros down the pipe
  always_comb begin
    data_next = '0;
    if (op_t'(operation) == OP_ASCII) begin
      if (asc_ok) begin
        data_next.found = 1'b1;
        data_next.index = 13'(code_high - AscFirst);
        data_next.count = asc_count;
        data_next.base  = asc_base(glyph_size);
      end
    end else begin
      if (sym_row || han_row) begin
        data_next.found = 1'b1;
        data_next.index = hz_index;
        data_next.count = hz_count;
        data_next.base  = hz_base(glyph_size);
      end
    end
  end

  // stage register
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

  // a miss leaves nothing for the later stages to add
  assert property (@(posedge clk) disable iff (rst)
    valid && !data.found |-> data.index == '0 && data.count == '0 && data.base == '0)
    else $error("decode miss carries nonzero payload");

  // an index never exceeds the last hanzi (row F7, low byte FF)
  assert property (@(posedge clk) disable iff (rst)
    valid |-> data.index <= 13'd7614)
    else $error("glyph index out of range");

  // a held stage keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(data))
    else $error("decode stage lost data on stall");

endmodule

// ----- sv/gra_mult.sv -----
// ----------------------------------------------------------------------------
// gra_mult
// Second stage: glyph index times bytes per glyph.
// ----------------------------------------------------------------------------
module gra_mult (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gra_pkg::dec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gra_pkg::mul_t out_data
);
  import gra_pkg::*;

  logic valid;
  mul_t data;
  mul_t data_next;

  // 13 x 8 product
  always_comb begin
    data_next.found   = in_data.found;
    data_next.product = ProdW'(in_data.index) * ProdW'(in_data.count);
    data_next.count   = in_data.count;
    data_next.base    = in_data.base;
  end

  // stage register
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

  // a miss has a zero product
  assert property (@(posedge clk) disable iff (rst)
    valid && !data.found |-> data.product == '0)
    else $error("multiply miss has nonzero product");

  // a held stage keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(data))
    else $error("multiply stage lost data on stall");

  // a bubble enters when the decode side has nothing
  assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> !valid)
    else $error("multiply stage invented an item");

endmodule

// ----- sv/gra_addr.sv -----
// ----------------------------------------------------------------------------
// gra_addr
// Third stage: base plus offset, held in the output register.
// ----------------------------------------------------------------------------
module gra_addr (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gra_pkg::mul_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      found,
  output logic [gra_pkg::AddrW-1:0]  rom_address,
  output logic [gra_pkg::CountW-1:0] byte_count
);
  import gra_pkg::*;

  logic              valid;
  logic              found_r;
  logic [AddrW-1:0]  addr_r;
  logic [CountW-1:0] count_r;

  // output register
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      found_r <= in_data.found;
      addr_r  <= AddrW'(in_data.product) + in_data.base;
      count_r <= in_data.count;
    end
  end

  assign out_valid   = valid;
  assign found       = found_r;
  assign rom_address = addr_r;
  assign byte_count  = count_r;

  // a miss reports zero address and count
  assert property (@(posedge clk) disable iff (rst)
    valid && !found_r |-> addr_r == '0 && count_r == '0)
    else $error("miss with nonzero address or count");

  // a held result keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(addr_r) && $stable(count_r))
    else $error("output register lost data on stall");

endmodule

// ----- dv/glyph_rom_address_test.sv -----
// ----------------------------------------------------------------------------
// glyph_rom_address_test
// Self-checking bench for the glyph ROM address generator.
// Sends GB2312 and ASCII codes through the input stream across a series of
// glyph sizes. A scoreboard predicts found, ROM address and byte count for
// each accepted code and checks the result stream in order. Both sides run
// with random pacing, then with no idles or stalls in the last regime.
// ----------------------------------------------------------------------------
module glyph_rom_address_test;
  import gra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseItems = 145;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit = 400000;

  // expected lookup result
  typedef struct {
    logic              found;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] count;
  } glyph_hit_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each lookup and checks results in order
  // --------------------------------------------------------------------------
  class glyph_scoreboard;
    glyph_hit_t       lookups_due[$];
    logic [SizeW-1:0] glyph_size;
    int unsigned      mismatches;
    int unsigned      lookups_checked;

    function new();
      glyph_size      = SizeReset;
      mismatches      = 0;
      lookups_checked = 0;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    function int unsigned pending();
      return lookups_due.size();
    endfunction

    // compute the expected result for one accepted code
    function void note_code(op_t op, logic [CodeW-1:0] hi, logic [CodeW-1:0] lo);
      int unsigned      s;
      int unsigned      rows;
      int unsigned      index;
      logic [CountW-1:0] count;
      logic [AddrW-1:0]  base;
      logic             ok;
      glyph_hit_t       hit;
      s     = 32'(glyph_size);
      rows  = (s + 7) >> 3;
      index = 0;
      ok    = 1'b0;
      base  = '0;
      if (op == OP_GB2312) begin
        count = CountW'(rows * s);
        case (s)
          16: base = HzBase16;
          24: base = HzBase24;
          32: base = HzBase32;
          default: base = '0;
        endcase
        if (lo >= 8'hA1 && hi >= 8'hA1 && hi <= 8'hA9) begin
          index = (hi - 8'hA1) * 94 + (lo - 8'hA1);
          ok    = 1'b1;
        end else if (lo >= 8'hA1 && hi >= 8'hB0 && hi <= 8'hF7) begin
          index = (hi - 8'hB0) * 94 + (lo - 8'hA1) + 846;
          ok    = 1'b1;
        end
      end else begin
        // 24-point ASCII glyphs are always 48 bytes
        count = (s == 24) ? 8'd48 : CountW'(rows * (s >> 1));
        case (s)
          7:  base = AscBase7;
          8:  base = AscBase8;
          12: base = AscBase12;
          16: base = AscBase16;
          24: base = AscBase24;
          32: base = AscBase32;
          default: base = '0;
        endcase
        if (hi >= 8'h20 && hi <= 8'h7E) begin
          index = 32'(hi - 8'h20);
          ok    = 1'b1;
        end
      end
      hit.found   = ok;
      hit.address = ok ? AddrW'(index * count + base) : '0;
      hit.count   = ok ? count : '0;
      lookups_due.push_back(hit);
    endfunction

    // compare one accepted result with the oldest prediction
    task check_result(logic found, logic [AddrW-1:0] address, logic [CountW-1:0] count);
      glyph_hit_t want;
      if (lookups_due.size() == 0) begin
        report($sformatf("unexpected result found=%0b addr=%06h count=%0d",
                         found, address, count));
      end else begin
        want = lookups_due.pop_front();
        lookups_checked++;
        if (found !== want.found)
          report($sformatf("found %0b, want %0b", found, want.found));
        if (address !== want.address)
          report($sformatf("rom_address %06h, want %06h", address, want.address));
        if (count !== want.count)
          report($sformatf("byte_count %0d, want %0d", count, want.count));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SizeW-1:0]  cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;   // [7:0] code_high, [15:8] code_low
  logic [0:0]        s_tuser = '0;   // [0] operation
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;        // [23:0] rom_address, [31:24] byte_count
  logic [0:0]        m_tuser;        // [0] found

  glyph_scoreboard board = new();
  int unsigned     send_idle_pct = 17;
  int unsigned     recv_stall_pct = 60;
  int unsigned     codes_sent = 0;
  int unsigned     cycles = 0;

  // phase sizes; negative means a random size
  int phase_sizes [12] = '{16, 12, 24, 32, 7, 8, 1, 0, 63, -1, -1, 16};

  // directed codes, packed as {operation, code_high, code_low}
  logic [16:0] directed_codes [22] = '{
    {OP_ASCII,  8'h20, 8'h00}, {OP_ASCII,  8'h7E, 8'hFF}, {OP_ASCII,  8'h1F, 8'h5A},
    {OP_ASCII,  8'h7F, 8'hA1}, {OP_ASCII,  8'h00, 8'h00}, {OP_ASCII,  8'hFF, 8'hFF},
    {OP_GB2312, 8'hA1, 8'hA1}, {OP_GB2312, 8'hA9, 8'hFF}, {OP_GB2312, 8'hA1, 8'hA0},
    {OP_GB2312, 8'hA0, 8'hA1}, {OP_GB2312, 8'hAA, 8'hA1}, {OP_GB2312, 8'hAF, 8'hC0},
    {OP_GB2312, 8'hB0, 8'hA1}, {OP_GB2312, 8'hB0, 8'hA0}, {OP_GB2312, 8'hF7, 8'hFF},
    {OP_GB2312, 8'hF8, 8'hA1}, {OP_GB2312, 8'h00, 8'h00}, {OP_GB2312, 8'hFF, 8'hFF},
    {OP_GB2312, 8'h41, 8'h42}, {OP_ASCII,  8'h41, 8'h00}, {OP_GB2312, 8'hD7, 8'hF9},
    {OP_ASCII,  8'hA1, 8'hA1}
  };

  glyph_rom_address DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  always #4 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(m_tuser[0], m_tdata[23:0], m_tdata[31:24]);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // present one code and hold it until the transaction completes
  task automatic send_code(op_t op, logic [CodeW-1:0] hi, logic [CodeW-1:0] lo);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lo, hi};
    s_tuser  <= op;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    board.note_code(op, hi, lo);
    codes_sent++;
    // pacing regime follows overall progress
    if (codes_sent == 580) begin
      send_idle_pct  = 60;
      recv_stall_pct = 17;
    end else if (codes_sent == 1160) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  endtask

  // random code, mostly well-formed
  task automatic send_random_code();
    int unsigned       pick;
    op_t               op;
    logic [CodeW-1:0]  hi;
    logic [CodeW-1:0]  lo;
    pick = $urandom_range(99);
    if (pick < 40) begin
      op = OP_GB2312;
      hi = $urandom_range(1) ? CodeW'($urandom_range(8'hA9, 8'hA1))
                             : CodeW'($urandom_range(8'hF7, 8'hB0));
      lo = CodeW'($urandom_range(8'hFF, 8'hA1));
    end else if (pick < 70) begin
      op = OP_ASCII;
      hi = CodeW'($urandom_range(8'h7E, 8'h20));
      lo = CodeW'($urandom_range(255));
    end else begin
      op = op_t'($urandom_range(1));
      hi = CodeW'($urandom_range(255));
      lo = CodeW'($urandom_range(255));
    end
    send_code(op, hi, lo);
  endtask

  // let the pipe empty, then write glyph_size
  task automatic write_glyph_size(logic [SizeW-1:0] value);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.glyph_size = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    int unsigned drain;
    logic [SizeW-1:0] next_size;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 12; p++) begin
      if (p != 0) begin
        next_size = (phase_sizes[p] < 0) ? SizeW'($urandom_range(63))
                                         : SizeW'(phase_sizes[p]);
        write_glyph_size(next_size);
      end
      if (p == 0)
        foreach (directed_codes[i])
          send_code(op_t'(directed_codes[i][16]), directed_codes[i][15:8],
                    directed_codes[i][7:0]);
      for (int n = 0; n < PhaseItems; n++)
        send_random_code();
      @(negedge clk);
      s_tvalid <= 1'b0;
    end

    // drain outstanding results
    while (board.pending() != 0) @(posedge clk);
    for (drain = 0; drain < DrainCycles; drain++) @(posedge clk);

    $display("Sent %0d codes over 12 glyph size settings (including 0 and 63),",
             codes_sent);
    $display("checked %0d results under three pacing regimes, %0d mismatches.",
             board.lookups_checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
